[src/bur_pkg.sv]
// Shared types and constants for the bounded undo/redo history.
package bur_pkg;

  localparam int unsigned DEFAULT_DEPTH        = 16;
  localparam int unsigned DEFAULT_PAYLOAD_BITS = 64;
  localparam int unsigned SNAP_W               = 64;

  typedef enum logic [2:0] {
    OP_CAPTURE    = 3'd0,
    OP_RESET      = 3'd1,
    OP_STEP_BACK  = 3'd2,
    OP_STEP_FWD   = 3'd3,
    OP_BRANCH     = 3'd4,
    OP_CLEAR_FLAG = 3'd5,
    OP_QUERY      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

  // Tag word as it sits in the tag memory.
  typedef struct packed {
    logic [7:0] layout;
    logic [1:0] last_mover;
    logic [1:0] player;
    logic [7:0] moves;
  } tag_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic              has_board;
    logic              has_context;
    logic [SNAP_W-1:0] snapshot_data;
    logic [7:0]        move_count_in;
    logic [1:0]        player_in;
    logic [1:0]        last_mover_in;
    logic [7:0]        layout_in;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [4:0]        removed;
    logic [SNAP_W-1:0] snapshot_out;
    logic [7:0]        move_count_out;
    logic [1:0]        player_out;
    logic [1:0]        last_mover_out;
    logic [7:0]        layout_out;
    logic [3:0]        view_out;
    logic [4:0]        count_out;
    logic              is_live;
    logic              has_start;
    logic              disqualified_out;
  } out_item_t;

endpackage

[src/bur_if.sv]
// Valid/ready channel interfaces for the history's command and result streams.
interface bur_in_if;
  logic               valid;
  logic               ready;
  bur_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bur_out_if;
  logic               valid;
  logic               ready;
  bur_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/bounded_undo_redo_history.sv]
// Bounded undo/redo history: circular snapshot store in two synchronous RAMs.
// Query, clear flag, failed steps, live branch and reset without board register their result
// directly; a successful step first does one RAM read; capture and other branches first run
// a RAM scan over the new count, which rebuilds the start-entry flag.
// One command is in flight at a time; the next is taken the cycle after a result registers.
// Reset (rst_ni low) empties the history, clears the flag; no RAM clearing pass is needed.
module bounded_undo_redo_history #(
  parameter int unsigned DEPTH        = bur_pkg::DEFAULT_DEPTH,
  parameter int unsigned PAYLOAD_BITS = bur_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bur_in_if.sink     req_i,
  bur_out_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CMP_W-1:0] WRAP     = CMP_W'(DEPTH);

  // Logical position 0 (the newest entry) lives at physical address head_q.
  // Older entries follow at increasing addresses, modulo DEPTH.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [CMP_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= WRAP) begin
      sum = sum - WRAP;
    end
    return sum[IDX_W-1:0];
  endfunction

  // Control state.
  bur_pkg::state_e   state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  view_q, view_d;
  logic              flag_q, flag_d;
  logic              start_q, start_d;
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic              scan_vld_q, scan_vld_d;
  logic              out_vld_q, out_vld_d;

  // Result payload held between the work and the output register.
  logic                    ok_q, ok_d;
  logic [IDX_W-1:0]        removed_q, removed_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
  bur_pkg::tag_t           res_tag_q, res_tag_d;
  bur_pkg::out_item_t      out_q, out_d;

  // Snapshot RAMs and their single read and write ports.
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];
  bur_pkg::tag_t           tag_mem [DEPTH];
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic [PAYLOAD_BITS-1:0] wr_pay;
  bur_pkg::tag_t           wr_tag;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_ra;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;
  bur_pkg::tag_t           rd_tag_q;

  // Helpers.
  logic              accept;
  logic              do_capture;
  logic [IDX_W-1:0]  head_dec;
  logic [CNT_W-1:0]  cnt_base;
  logic [IDX_W-1:0]  tgt_back;
  logic [IDX_W-1:0]  tgt_fwd;
  logic              can_back;

  assign req_i.ready = (state_q == bur_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // A reset with a board is a capture that starts from an empty history.
  assign do_capture = (req_i.data.operation == bur_pkg::OP_CAPTURE) ||
                      ((req_i.data.operation == bur_pkg::OP_RESET) && req_i.data.has_board);
  assign cnt_base   = (req_i.data.operation == bur_pkg::OP_RESET) ? '0 : count_q;
  assign head_dec   = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
  assign tgt_back   = view_q + IDX_W'(1);
  assign tgt_fwd    = view_q - IDX_W'(1);
  assign can_back   = (CMP_W'(view_q) + CMP_W'(1)) < CMP_W'(count_q);

  // Without context the entry keeps only its move count.
  always_comb begin
    wr_tag.moves = req_i.data.move_count_in;
    if (req_i.data.has_context) begin
      wr_tag.player     = req_i.data.player_in;
      wr_tag.last_mover = req_i.data.last_mover_in;
      wr_tag.layout     = req_i.data.layout_in;
    end else begin
      wr_tag.player     = '0;
      wr_tag.last_mover = '0;
      wr_tag.layout     = '0;
    end
  end
  assign wr_pay = req_i.data.snapshot_data[PAYLOAD_BITS-1:0];

  // Next state and datapath control.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    view_d     = view_q;
    flag_d     = flag_q;
    start_d    = start_q;
    scan_idx_d = scan_idx_q;
    scan_vld_d = scan_vld_q;
    ok_d       = ok_q;
    removed_d  = removed_q;
    res_pay_d  = res_pay_q;
    res_tag_d  = res_tag_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    mem_we     = 1'b0;
    mem_wa     = head_dec;
    mem_re     = 1'b0;
    mem_ra     = phys(head_q, scan_idx_q[IDX_W-1:0]);

    case (state_q)
      bur_pkg::S_IDLE: begin
        if (accept) begin
          ok_d      = 1'b1;
          removed_d = '0;
          res_pay_d = '0;
          res_tag_d = '0;
          state_d   = bur_pkg::S_DONE;
          case (bur_pkg::op_e'(req_i.data.operation))
            bur_pkg::OP_RESET: begin
              count_d = '0;
              view_d  = '0;
              flag_d  = 1'b0;
              start_d = 1'b0;
            end
            bur_pkg::OP_STEP_BACK: begin
              if (can_back) begin
                mem_re  = 1'b1;
                mem_ra  = phys(head_q, tgt_back);
                view_d  = tgt_back;
                state_d = bur_pkg::S_READ;
              end else begin
                ok_d = 1'b0;
              end
            end
            bur_pkg::OP_STEP_FWD: begin
              if (view_q != '0) begin
                mem_re  = 1'b1;
                mem_ra  = phys(head_q, tgt_fwd);
                view_d  = tgt_fwd;
                state_d = bur_pkg::S_READ;
              end else begin
                ok_d = 1'b0;
              end
            end
            bur_pkg::OP_BRANCH: begin
              // Dropping the newer entries just moves the head past them.
              if (view_q != '0) begin
                removed_d = view_q;
                head_d    = phys(head_q, view_q);
                if (CMP_W'(count_q) > CMP_W'(view_q)) begin
                  count_d = CNT_W'(CMP_W'(count_q) - CMP_W'(view_q));
                end else begin
                  count_d = CNT_W'(1);
                end
                view_d     = '0;
                flag_d     = 1'b1;
                start_d    = 1'b0;
                scan_idx_d = '0;
                scan_vld_d = 1'b0;
                state_d    = bur_pkg::S_SCAN;
              end
            end
            bur_pkg::OP_CLEAR_FLAG: begin
              flag_d = 1'b0;
            end
            default: begin
            end
          endcase

          // Capture writes at the slot below the head; when full that slot
          // holds the oldest entry, which is overwritten.
          if (do_capture) begin
            mem_we     = 1'b1;
            mem_wa     = head_dec;
            head_d     = head_dec;
            count_d    = (cnt_base == CNT_FULL) ? cnt_base : cnt_base + CNT_W'(1);
            view_d     = '0;
            start_d    = 1'b0;
            scan_idx_d = '0;
            scan_vld_d = 1'b0;
            state_d    = bur_pkg::S_SCAN;
          end
        end
      end

      bur_pkg::S_READ: begin
        res_pay_d = rd_pay_q;
        res_tag_d = rd_tag_q;
        state_d   = bur_pkg::S_DONE;
      end

      bur_pkg::S_SCAN: begin
        // One read issued per cycle; its data is checked in the cycle after.
        if (scan_vld_q && (rd_tag_q.moves == '0)) begin
          start_d = 1'b1;
        end
        if (scan_idx_q < count_q) begin
          mem_re     = 1'b1;
          mem_ra     = phys(head_q, scan_idx_q[IDX_W-1:0]);
          scan_idx_d = scan_idx_q + CNT_W'(1);
          scan_vld_d = 1'b1;
        end else begin
          scan_vld_d = 1'b0;
          if (!scan_vld_q) begin
            state_d = bur_pkg::S_DONE;
          end
        end
      end

      bur_pkg::S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d              = 1'b1;
          out_d.ok               = ok_q;
          out_d.removed          = 5'(removed_q);
          out_d.snapshot_out     = bur_pkg::SNAP_W'(res_pay_q);
          out_d.move_count_out   = res_tag_q.moves;
          out_d.player_out       = res_tag_q.player;
          out_d.last_mover_out   = res_tag_q.last_mover;
          out_d.layout_out       = res_tag_q.layout;
          out_d.view_out         = 4'(view_q);
          out_d.count_out        = 5'(count_q);
          out_d.is_live          = (view_q == '0);
          out_d.has_start        = start_q;
          out_d.disqualified_out = flag_q;
          state_d                = bur_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bur_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bur_pkg::S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      view_q     <= '0;
      flag_q     <= 1'b0;
      start_q    <= 1'b0;
      scan_idx_q <= '0;
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      view_q     <= view_d;
      flag_q     <= flag_d;
      start_q    <= start_d;
      scan_idx_q <= scan_idx_d;
      scan_vld_q <= scan_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    removed_q <= removed_d;
    res_pay_q <= res_pay_d;
    res_tag_q <= res_tag_d;
    out_q     <= out_d;
  end

  // The write happens only on the accepting edge and every read comes after
  // it, so the FSM itself keeps reads and writes to one entry apart.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pay_mem[mem_wa] <= wr_pay;
      tag_mem[mem_wa] <= wr_tag;
    end
    if (mem_re) begin
      rd_pay_q <= pay_mem[mem_ra];
      rd_tag_q <= tag_mem[mem_ra];
    end
  end

`ifndef SYNTH
  a_view_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMP_W'(view_q) < CMP_W'(count_q)) || ((count_q == '0) && (view_q == '0)))
    else $error("view position points beyond the stored entries");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count exceeds the store depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(head_q) < WRAP)
    else $error("head pointer outside the store");

  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (accept && (state_d == bur_pkg::S_SCAN)))
    else $error("store written outside an accepted capture");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bur_pkg::S_DONE && out_vld_q && !rsp_o.ready) |=>
      (state_q == bur_pkg::S_DONE))
    else $error("result finished while the output register was still full");
`endif

endmodule
